// File: rtl/lfsa_pkg.sv
package lfsa_pkg;

  localparam int TIME_W    = 28;
  localparam int LIMIT_W   = 7;
  localparam int IDX_OUT_W = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // item operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // update command from the pipeline to the slot bank
  typedef struct packed {
    logic en;
    logic clear;
    logic grant;
  } lfsa_upd_t;

endpackage

// File: rtl/lowest_free_slot_allocator.sv
// a word is registered in the first stage, its result word in the output register
// throughput: one word per cycle when out_stall is low, set by the parallel compare
//   of all NUM_SLOTS release times and the lowest-free priority encoder
// reset: all slots free, slots_in_use back to 64, both pipeline stages empty;
//   stored release times are not reset and are only read for busy slots
module lowest_free_slot_allocator import lfsa_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [TIME_W-1:0]    arrival_time,
  input  logic [TIME_W-1:0]    departure_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 granted,
  output logic [IDX_OUT_W-1:0] slot_index
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [LIMIT_W-1:0]   slots_in_use;
  logic                 s1_valid;
  logic                 s1_op;
  logic [TIME_W-1:0]    s1_arrival;
  logic [TIME_W-1:0]    s1_departure;
  logic                 out_adv;
  logic                 s1_adv;
  logic                 in_acc;
  logic                 found;
  logic                 grant;
  logic [IDX_W-1:0]     found_idx;
  logic [NUM_SLOTS-1:0] free_mask;
  lfsa_upd_t            upd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slots_in_use <= cfg_data;
    end
  end

  assign out_adv  = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_adv;
  assign in_stall = s1_valid && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op        <= op;
      s1_arrival   <= arrival_time;
      s1_departure <= departure_time;
    end
  end

  lfsa_slot_bank #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_bank (
    .clk          (clk),
    .rst          (rst),
    .slots_in_use (slots_in_use),
    .arrival      (s1_arrival),
    .departure    (s1_departure),
    .upd          (upd),
    .grant_idx    (found_idx),
    .free_mask    (free_mask)
  );

  lfsa_prio_enc #(
    .N     (NUM_SLOTS),
    .IDX_W (IDX_W)
  ) u_enc (
    .req   (free_mask),
    .found (found),
    .idx   (found_idx)
  );

  assign grant     = found && (s1_op == OP_ALLOC);
  assign upd.en    = s1_adv;
  assign upd.clear = (s1_op == OP_CLEAR);
  assign upd.grant = grant;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // slot index is masked to the output width, and is zero when not granted
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      granted    <= grant;
      slot_index <= grant ? IDX_OUT_W'(found_idx) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty first stage");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced word did not reach the output register");

  a_found_is_free: assert property (@(posedge clk) disable iff (rst)
    found |-> free_mask[found_idx])
    else $error("encoder picked a slot that is not free");

  a_reject_zero_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (slot_index == '0))
    else $error("rejected result carries a non-zero index");
`endif

endmodule

// File: rtl/lfsa_prio_enc.sv
module lfsa_prio_enc #(
  parameter int N     = 64,
  parameter int IDX_W = 6
) (
  input  logic [N-1:0]     req,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  // lowest set bit wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

// File: rtl/lfsa_slot_bank.sv
module lfsa_slot_bank import lfsa_pkg::*; #(
  parameter int NUM_SLOTS = 64,
  parameter int IDX_W     = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] slots_in_use,
  input  logic [TIME_W-1:0]  arrival,
  input  logic [TIME_W-1:0]  departure,
  input  lfsa_upd_t          upd,
  input  logic [IDX_W-1:0]   grant_idx,
  output logic [NUM_SLOTS-1:0] free_mask
);

  logic [NUM_SLOTS-1:0] busy;
  logic [NUM_SLOTS-1:0] busy_next;
  logic [NUM_SLOTS-1:0] kept;
  logic [NUM_SLOTS-1:0] eligible;
  logic [TIME_W-1:0]    release_time [NUM_SLOTS];

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    // a slot is released when its time is strictly earlier than arrival, or by a clear
    assign kept[g]      = busy[g] && !(release_time[g] < arrival);
    assign eligible[g]  = g < int'(slots_in_use);
    assign free_mask[g] = !kept[g] && eligible[g];
  end

  always_comb begin
    busy_next = kept;
    if (upd.grant) begin
      busy_next[grant_idx] = 1'b1;
    end
    if (upd.clear) begin
      busy_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (upd.en) begin
      busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && !upd.clear && upd.grant) begin
      release_time[grant_idx] <= departure;
    end
  end

endmodule
